// ===== sv/hsfd_pkg.sv =====
// Shared types, constants and the CRC helper for the sensor frame decoder.
package hsfd_pkg;

  // CRC-8 settings of the sensor reply.
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Fixed-point scaling: value = floor(scale * raw / full_scale), minus the offset for temperature.
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  // Widths of the scaled products.
  localparam int TPROD_W = 31;
  localparam int HPROD_W = 30;

  // Position of the next byte within the six-byte reply.
  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // One received byte.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  // One decoded reply.
  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [13:0]        humidity_centi;
    logic [15:0]        raw_temperature;
    logic [15:0]        raw_humidity;
    logic               temp_crc_ok;
    logic               humidity_crc_ok;
    logic               frame_ok;
  } out_t;

  // Assembled reply handed from the byte assembler to the scaler.
  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [15:0] raw_humidity;
    logic        temp_crc_ok;
    logic        humidity_crc_ok;
  } frame_t;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/hsfd_assembler.sv =====
// Collects the reply bytes, runs the per-word CRC and flags a complete reply.
module hsfd_assembler (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_accept,
  input  hsfd_pkg::in_t   in_data,
  output logic            frm_vld,
  output hsfd_pkg::frame_t frm
);

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] temp_word_r, temp_word_nxt;
  logic [15:0] hum_word_r, hum_word_nxt;
  logic        temp_flag_r, temp_flag_nxt;
  logic [2:0]  pos_eff;
  logic        hum_ok;

  // A start flag or an out-of-range position restarts at the first byte.
  assign pos_eff = (in_data.frame_start || (pos_r > hsfd_pkg::POS_H_CRC)) ?
                   hsfd_pkg::POS_T_HI : pos_r;
  assign hum_ok  = (crc_r == in_data.rx_byte);

  // Next-state logic for one accepted byte.
  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    temp_word_nxt = temp_word_r;
    hum_word_nxt  = hum_word_r;
    temp_flag_nxt = temp_flag_r;
    frm_vld       = 1'b0;
    if (in_accept) begin
      case (pos_eff)
        hsfd_pkg::POS_T_HI: begin
          temp_word_nxt[15:8] = in_data.rx_byte;
          crc_nxt = hsfd_pkg::crc8_byte(hsfd_pkg::CRC_INIT, in_data.rx_byte);
          pos_nxt = hsfd_pkg::POS_T_LO;
        end
        hsfd_pkg::POS_T_LO: begin
          temp_word_nxt[7:0] = in_data.rx_byte;
          crc_nxt = hsfd_pkg::crc8_byte(crc_r, in_data.rx_byte);
          pos_nxt = hsfd_pkg::POS_T_CRC;
        end
        hsfd_pkg::POS_T_CRC: begin
          temp_flag_nxt = (crc_r == in_data.rx_byte);
          crc_nxt = hsfd_pkg::CRC_INIT;
          pos_nxt = hsfd_pkg::POS_H_HI;
        end
        hsfd_pkg::POS_H_HI: begin
          hum_word_nxt[15:8] = in_data.rx_byte;
          crc_nxt = hsfd_pkg::crc8_byte(hsfd_pkg::CRC_INIT, in_data.rx_byte);
          pos_nxt = hsfd_pkg::POS_H_LO;
        end
        hsfd_pkg::POS_H_LO: begin
          hum_word_nxt[7:0] = in_data.rx_byte;
          crc_nxt = hsfd_pkg::crc8_byte(crc_r, in_data.rx_byte);
          pos_nxt = hsfd_pkg::POS_H_CRC;
        end
        default: begin
          // Sixth byte closes the reply.
          crc_nxt = hsfd_pkg::CRC_INIT;
          pos_nxt = hsfd_pkg::POS_T_HI;
          frm_vld = 1'b1;
        end
      endcase
    end
  end

  // The finished reply, valid together with frm_vld.
  assign frm.raw_temperature = temp_word_r;
  assign frm.raw_humidity    = hum_word_r;
  assign frm.temp_crc_ok     = temp_flag_r;
  assign frm.humidity_crc_ok = hum_ok;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= hsfd_pkg::POS_T_HI;
      crc_r       <= hsfd_pkg::CRC_INIT;
      temp_word_r <= '0;
      hum_word_r  <= '0;
      temp_flag_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      temp_word_r <= temp_word_nxt;
      hum_word_r  <= hum_word_nxt;
      temp_flag_r <= temp_flag_nxt;
    end
  end

  // A start byte always lands as the first byte of the reply.
  a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.frame_start |=> pos_r == hsfd_pkg::POS_T_LO)
    else $error("start byte did not restart the reply");

  // After a complete reply the next byte is the first of a new one.
  a_frame_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    frm_vld |=> pos_r == hsfd_pkg::POS_T_HI && crc_r == hsfd_pkg::CRC_INIT)
    else $error("position or CRC not restarted after a reply");

endmodule

// ===== sv/hsfd_scale.sv =====
// Two-stage scaler: multiply by the scale, then divide by full scale and offset.
module hsfd_scale (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             frm_vld,
  input  hsfd_pkg::frame_t frm,
  output logic             frm_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output hsfd_pkg::out_t   out_data
);

  logic                         s1_v_r;
  hsfd_pkg::frame_t             s1_frm_r;
  logic [hsfd_pkg::TPROD_W-1:0] tprod_r;
  logic [hsfd_pkg::HPROD_W-1:0] hprod_r;
  logic                         out_v_r;
  hsfd_pkg::out_t               out_r, out_nxt;
  logic                         s2_ready;
  logic [14:0]                  t_q0, t_q;
  logic [13:0]                  h_q0, h_q;
  logic [16:0]                  t_rem, h_rem;

  // Each stage moves on when it is empty or its successor takes a transfer.
  assign s2_ready  = !out_v_r || out_ready;
  assign frm_ready = !s1_v_r || s2_ready;

  // Stage one: products of the raw words with their scales.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (frm_ready) begin
      s1_v_r <= frm_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_ready && frm_vld) begin
      s1_frm_r <= frm;
      tprod_r  <= hsfd_pkg::TPROD_W'(hsfd_pkg::TEMP_SCALE) *
                  hsfd_pkg::TPROD_W'(frm.raw_temperature);
      hprod_r  <= hsfd_pkg::HPROD_W'(hsfd_pkg::HUM_SCALE) *
                  hsfd_pkg::HPROD_W'(frm.raw_humidity);
    end
  end

  // Division by 65535: x = q0*65535 + (q0 + low half), one correction step.
  assign t_q0  = tprod_r[30:16];
  assign t_rem = 17'(tprod_r[15:0]) + 17'(t_q0);
  assign t_q   = t_q0 + 15'(t_rem >= hsfd_pkg::FULL_SCALE);
  assign h_q0  = hprod_r[29:16];
  assign h_rem = 17'(hprod_r[15:0]) + 17'(h_q0);
  assign h_q   = h_q0 + 14'(h_rem >= hsfd_pkg::FULL_SCALE);

  // Result assembly; the offset subtraction wraps into two's complement.
  always_comb begin
    out_nxt.temp_centi      = $signed(t_q - hsfd_pkg::TEMP_OFFSET);
    out_nxt.humidity_centi  = h_q;
    out_nxt.raw_temperature = s1_frm_r.raw_temperature;
    out_nxt.raw_humidity    = s1_frm_r.raw_humidity;
    out_nxt.temp_crc_ok     = s1_frm_r.temp_crc_ok;
    out_nxt.humidity_crc_ok = s1_frm_r.humidity_crc_ok;
    out_nxt.frame_ok        = s1_frm_r.temp_crc_ok && s1_frm_r.humidity_crc_ok;
  end

  // Stage two: output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_ready) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // A stalled middle stage keeps its item.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_ready |=> s1_v_r && $stable(tprod_r) && $stable(hprod_r))
    else $error("middle stage lost or changed a stalled item");

  // The frame flag agrees with both word flags.
  a_frame_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.frame_ok ==
                  (out_data.temp_crc_ok && out_data.humidity_crc_ok))
    else $error("frame flag disagrees with word flags");

  // Humidity never exceeds full scale.
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.humidity_centi <= 14'(hsfd_pkg::HUM_SCALE))
    else $error("humidity above full scale");

endmodule

// ===== sv/humidity_sensor_frame_decoder_unit.sv =====
// Channel | Ports                        | Payload
// in      | in_valid, in_ready, in_data  | hsfd_pkg::in_t  (rx_byte, frame_start)
// out     | out_valid, out_ready, out_data | hsfd_pkg::out_t (scaled values, raw words, flags)
//
// One byte is taken per cycle while in_ready is high; a result follows the sixth byte of a reply.
// After the sixth byte's transfer the result is registered first by the scale multipliers,
// then by the divide-by-full-scale correction and offset, before out_valid rises.
// Reset (rst_n, synchronous) empties both stages and restarts at the first byte.
// in_ready drops only when both result stages are full and out_ready is low.
module humidity_sensor_frame_decoder_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hsfd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hsfd_pkg::out_t out_data
);

  logic             in_accept;
  logic             frm_vld;
  logic             frm_ready;
  hsfd_pkg::frame_t frm;

  // A byte is taken whenever the scaler can hold a possible reply.
  assign in_ready  = frm_ready;
  assign in_accept = in_valid && frm_ready;

  hsfd_assembler u_assembler (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_data   (in_data),
    .frm_vld   (frm_vld),
    .frm       (frm)
  );

  hsfd_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .frm_vld   (frm_vld),
    .frm       (frm),
    .frm_ready (frm_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
